FILE: hdl/tsc_pkg.sv
// Package for the Taylor sine/cosine unit: widths, fixed-point and reciprocal constants.
// Used by tsc_mul, tsc_div, taylor_sine_cosine_unit and the testbench; depends on nothing.

package tsc_pkg;

   localparam int ANGLE_W     = 32;
   localparam int VALUE_W     = 32;
   localparam int ACC_W       = 34;
   localparam int MUL_W       = 34;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int FRAC_BITS   = 29;
   localparam int SHIFT_W     = PROD_W - FRAC_BITS;
   localparam int DIV_W       = 33;
   localparam int DVSR_W      = 6;
   localparam int QUO_W       = 31;
   localparam int RECIP_SH_21 = 37;
   localparam int RECIP_SH_5  = 34;
   localparam int RECIP_SH_3  = 34;

   localparam logic signed [ACC_W-1:0] PI_Q427      = 34'sd421657428;
   localparam logic signed [ACC_W-1:0] NEG_PI_Q427  = -34'sd421657428;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q427 = 34'sd210828714;
   localparam logic signed [ACC_W-1:0] TWO_PI_Q427  = 34'sd843314856;
   localparam logic signed [MUL_W-1:0] ONE_Q229     = 34'sd536870912;

   localparam logic [DVSR_W-1:0] DVSR_42 = 6'd42;
   localparam logic [DVSR_W-1:0] DVSR_20 = 6'd20;
   localparam logic [DVSR_W-1:0] DVSR_6  = 6'd6;

   // ceil(2^s / d), exact for the dividend widths after the pre-shift
   localparam logic signed [MUL_W-1:0] RECIP_21 = 34'sd6544712071;
   localparam logic signed [MUL_W-1:0] RECIP_5  = 34'sd3435973837;
   localparam logic signed [MUL_W-1:0] RECIP_3  = 34'sd5726623062;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      DIV_BY_42 = 2'd0,
      DIV_BY_20 = 2'd1,
      DIV_BY_6  = 2'd2
   } div_sel_type;

endpackage

FILE: hdl/tsc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tsc_pkg for operand and product widths.

module tsc_mul
   import tsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [MUL_W-1:0]  a,
   input  logic signed [MUL_W-1:0]  b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/tsc_div.sv
// Division by the constants 42, 20 and 6 through reciprocal multiplication:
// selects the shared multiplier operands and takes the quotient from the product.
// Depends on tsc_pkg for widths, reciprocals and the divisor select type.

module tsc_div
   import tsc_pkg::*;
(
   input  div_sel_type              sel,
   input  logic [DIV_W-1:0]         dividend,
   input  logic signed [PROD_W-1:0] prod,
   output logic signed [MUL_W-1:0]  mul_a,
   output logic signed [MUL_W-1:0]  mul_b,
   output logic [QUO_W-1:0]         quotient
);

   always_comb begin
      case (sel)
         DIV_BY_42: begin
            mul_a    = {2'b00, dividend[DIV_W-1:1]};
            mul_b    = RECIP_21;
            quotient = prod[RECIP_SH_21 +: QUO_W];
         end
         DIV_BY_20: begin
            mul_a    = {3'b000, dividend[DIV_W-1:2]};
            mul_b    = RECIP_5;
            quotient = prod[RECIP_SH_5 +: QUO_W];
         end
         DIV_BY_6: begin
            mul_a    = {2'b00, dividend[DIV_W-1:1]};
            mul_b    = RECIP_3;
            quotient = prod[RECIP_SH_3 +: QUO_W];
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            quotient = '0;
         end
      endcase
   end

endmodule

FILE: hdl/taylor_sine_cosine_unit.sv
// Seventh-order Taylor sine/cosine unit: top level with the sequencer.
// Depends on tsc_pkg, tsc_mul and tsc_div.
//
// Usage:
//   A request carries req_action (0 sine, 1 cosine) and req_angle in signed
//   Q4.27 radians. It is taken when req_valid and req_ready are both high.
//   The result rsp_value (signed Q2.29) is offered on rsp_valid and taken
//   when rsp_ready is high.
//   One request is in flight at a time: req_ready is high only while idle.
//   After acceptance the sequencer runs range reduction, then 7 passes
//   through the shared multiplier (the square, three Horner products and
//   three reciprocal products for the divisions by 42, 20 and 6), with a
//   state after each reciprocal product that takes its quotient. The next
//   request is taken the cycle after the response is taken.
//   A stalled receiver holds rsp_valid and rsp_value until rsp_ready.
//   Synchronous reset returns the sequencer to idle and drops any request
//   in progress; the data registers and the product register are not reset.

module taylor_sine_cosine_unit
   import tsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value
);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_REDUCE = 14'b00000000000010,
      S_SQUARE = 14'b00000000000100,
      S_DIV_A  = 14'b00000000001000,
      S_WAIT_A = 14'b00000000010000,
      S_MUL_B  = 14'b00000000100000,
      S_DIV_B  = 14'b00000001000000,
      S_WAIT_B = 14'b00000010000000,
      S_MUL_C  = 14'b00000100000000,
      S_DIV_C  = 14'b00001000000000,
      S_WAIT_C = 14'b00010000000000,
      S_MUL_R  = 14'b00100000000000,
      S_RESP   = 14'b01000000000000,
      S_SPARE  = 14'b10000000000000
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               red_cnt_ff, red_cnt_in;
   logic signed [ACC_W-1:0]  x_ff, x_in;
   logic [DIV_W-1:0]         x2_ff, x2_in;
   logic signed [MUL_W-1:0]  h_ff, h_in;

   logic signed [ACC_W-1:0]  x_start;
   logic signed [ACC_W-1:0]  x_step;
   logic signed [MUL_W-1:0]  xs;
   logic signed [MUL_W-1:0]  mul_a;
   logic signed [MUL_W-1:0]  mul_b;
   logic                     mul_en;
   logic signed [PROD_W-1:0] prod;
   logic signed [SHIFT_W-1:0] prod_sh;
   div_sel_type              div_sel;
   logic signed [MUL_W-1:0]  div_a;
   logic signed [MUL_W-1:0]  div_b;
   logic [QUO_W-1:0]         div_quot;
   logic signed [MUL_W-1:0]  h_next;
   logic                     sh_fits;

   assign x_start = ACC_W'(req_angle) + (req_action ? HALF_PI_Q427 : '0);

   always_comb begin
      if (x_ff > PI_Q427) begin
         x_step = x_ff - TWO_PI_Q427;
      end else if (x_ff < NEG_PI_Q427) begin
         x_step = x_ff + TWO_PI_Q427;
      end else begin
         x_step = x_ff;
      end
   end

   assign xs      = {x_ff[MUL_W-3:0], 2'b00};
   assign prod_sh = prod[PROD_W-1:FRAC_BITS];
   assign h_next  = ONE_Q229 - signed'(MUL_W'(div_quot));
   assign sh_fits = (prod_sh[SHIFT_W-1:VALUE_W-1] == '0)
                 || (prod_sh[SHIFT_W-1:VALUE_W-1] == '1);

   always_comb begin
      state_in   = state_ff;
      red_cnt_in = red_cnt_ff;
      x_in       = x_ff;
      x2_in      = x2_ff;
      h_in       = h_ff;
      mul_a      = xs;
      mul_b      = xs;
      mul_en     = 1'b0;
      div_sel    = DIV_BY_42;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in       = x_start;
               red_cnt_in = '0;
               state_in   = S_REDUCE;
            end
         end
         S_REDUCE: begin
            x_in       = x_step;
            red_cnt_in = red_cnt_ff + 1'b1;
            if (red_cnt_ff == 2'd2) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            mul_en   = 1'b1;
            state_in = S_DIV_A;
         end
         S_DIV_A: begin
            x2_in    = prod_sh[DIV_W-1:0];
            div_sel  = DIV_BY_42;
            mul_a    = div_a;
            mul_b    = div_b;
            mul_en   = 1'b1;
            state_in = S_WAIT_A;
         end
         S_WAIT_A: begin
            div_sel  = DIV_BY_42;
            h_in     = h_next;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            mul_a    = signed'({1'b0, x2_ff});
            mul_b    = h_ff;
            mul_en   = 1'b1;
            state_in = S_DIV_B;
         end
         S_DIV_B: begin
            div_sel  = DIV_BY_20;
            mul_a    = div_a;
            mul_b    = div_b;
            mul_en   = 1'b1;
            state_in = S_WAIT_B;
         end
         S_WAIT_B: begin
            div_sel  = DIV_BY_20;
            h_in     = h_next;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            mul_a    = signed'({1'b0, x2_ff});
            mul_b    = h_ff;
            mul_en   = 1'b1;
            state_in = S_DIV_C;
         end
         S_DIV_C: begin
            div_sel  = DIV_BY_6;
            mul_a    = div_a;
            mul_b    = div_b;
            mul_en   = 1'b1;
            state_in = S_WAIT_C;
         end
         S_WAIT_C: begin
            div_sel  = DIV_BY_6;
            h_in     = h_next;
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            mul_a    = xs;
            mul_b    = h_ff;
            mul_en   = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      red_cnt_ff <= red_cnt_in;
      x_ff       <= x_in;
      x2_ff      <= x2_in;
      h_ff       <= h_in;
   end

   tsc_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   tsc_div u_div (
      .sel      (div_sel),
      .dividend (prod_sh[DIV_W-1:0]),
      .prod     (prod),
      .mul_a    (div_a),
      .mul_b    (div_b),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      if (sh_fits) begin
         rsp_value = prod_sh[VALUE_W-1:0];
      end else if (prod_sh[SHIFT_W-1]) begin
         rsp_value = VALUE_MIN;
      end else begin
         rsp_value = VALUE_MAX;
      end
   end

endmodule

FILE: tb/sv/taylor_sine_cosine_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for taylor_sine_cosine_unit: angle requests, predicted sine/cosine values.
// Depends on tsc_pkg and the taylor_sine_cosine_unit RTL.

module taylor_sine_cosine_unit_tb
   import tsc_pkg::*;
();

   localparam int RANDOM_COUNT = 1700;
   localparam int QUIET_COUNT  = 200;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 600;
   localparam int UNIT_LATENCY = 13;
   localparam int WATCHDOG_MAX = 4000;

   class sincos_scoreboard;
      logic signed [VALUE_W-1:0] expected_values[$];
      int mismatches = 0;

      function logic signed [VALUE_W-1:0] taylor_value(logic act,
                                                       logic signed [ANGLE_W-1:0] ang);
         longint x, xs, x2, h1, h2, h3, r;
         x = ang;
         if (act) x += HALF_PI_Q427;
         repeat (3) begin
            if (x > PI_Q427) x -= TWO_PI_Q427;
            else if (x < NEG_PI_Q427) x += TWO_PI_Q427;
         end
         xs = x * 4;
         x2 = (xs * xs) >>> FRAC_BITS;
         h1 = ONE_Q229 - x2 / longint'(DVSR_42);
         h2 = ONE_Q229 - ((x2 * h1) >>> FRAC_BITS) / longint'(DVSR_20);
         h3 = ONE_Q229 - ((x2 * h2) >>> FRAC_BITS) / longint'(DVSR_6);
         r = (xs * h3) >>> FRAC_BITS;
         if (r > VALUE_MAX) r = VALUE_MAX;
         if (r < VALUE_MIN) r = VALUE_MIN;
         return r[VALUE_W-1:0];
      endfunction

      function void note_request(logic act, logic signed [ANGLE_W-1:0] ang);
         expected_values.push_back(taylor_value(act, ang));
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_value(logic signed [VALUE_W-1:0] got);
         logic signed [VALUE_W-1:0] want;
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request pending", got));
         end else begin
            want = expected_values.pop_front();
            if (got !== want)
               report_mismatch($sformatf("value got %0d expected %0d", got, want));
         end
      endtask

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_valid  = 1'b0;
   logic                      req_action = 1'b0;
   logic signed [ANGLE_W-1:0] req_angle  = '0;
   logic                      rsp_ready  = 1'b1;
   logic                      req_ready;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_value;

   sincos_scoreboard sb = new();

   bit idle_on      = 1'b1;
   bit stall_on     = 1'b1;
   bit hold_pending = 1'b0;
   int quiet_cycles = 0;

   logic signed [ANGLE_W-1:0] corner_angles [12];

   taylor_sine_cosine_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_angle  (req_angle),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value)
   );

   always #10 clock = ~clock;

   task automatic send_request(input logic act, input logic signed [ANGLE_W-1:0] ang);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_angle  <= ang;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, ang);
   endtask

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int kind, k;
      longint base;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         return $urandom;
      end else if (kind <= 6) begin
         return ANGLE_W'(longint'($urandom_range(0, TWO_PI_Q427)) - PI_Q427);
      end else if (kind <= 8) begin
         k = $urandom_range(0, 8);
         base = longint'(k - 4) * PI_Q427;
         if ($urandom_range(0, 1)) base += (k < 4) ? -HALF_PI_Q427 : HALF_PI_Q427;
         return ANGLE_W'(base + longint'($urandom_range(0, 16)) - 8);
      end
      return ANGLE_W'(longint'($urandom_range(0, 2000)) - 1000);
   endfunction

   initial begin : stimulus
      int i;
      corner_angles = '{
         '0, -1,
         ANGLE_W'(PI_Q427), ANGLE_W'(PI_Q427 + 1),
         ANGLE_W'(NEG_PI_Q427), ANGLE_W'(NEG_PI_Q427 - 1),
         ANGLE_W'(HALF_PI_Q427 + 1), ANGLE_W'(-3 * HALF_PI_Q427 - 1),
         32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_5555, 32'shaaaa_aaaa
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (corner_angles[j]) begin
         send_request(1'b0, corner_angles[j]);
         send_request(1'b1, corner_angles[j]);
      end
      for (i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT - QUIET_COUNT) begin
            idle_on  = 1'b0;
            stall_on = 1'b0;
         end
         if (i == HOLD_AT) hold_pending = 1'b1;
         send_request(1'($urandom_range(0, 1)), pick_angle());
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (UNIT_LATENCY + 8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_value(rsp_value);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
